@@ src/mi3_pkg.sv @@
// Shared types and widths for the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int ElemW = 32;            // Q16.16 element
  localparam int CofW  = 64;            // exact 2x2 cofactor
  localparam int DetW  = 98;            // exact signed determinant
  localparam int MagW  = DetW - 1;      // determinant magnitude
  localparam int Steps = ElemW;         // quotient bits, one per stage

  typedef struct packed {
    logic [ElemW-1:0] a00;
    logic [ElemW-1:0] a01;
    logic [ElemW-1:0] a02;
    logic [ElemW-1:0] a10;
    logic [ElemW-1:0] a11;
    logic [ElemW-1:0] a12;
    logic [ElemW-1:0] a20;
    logic [ElemW-1:0] a21;
    logic [ElemW-1:0] a22;
  } in_word_t;

  typedef struct packed {
    logic [ElemW-1:0] r00;
    logic [ElemW-1:0] r01;
    logic [ElemW-1:0] r02;
    logic [ElemW-1:0] r10;
    logic [ElemW-1:0] r11;
    logic [ElemW-1:0] r12;
    logic [ElemW-1:0] r20;
    logic [ElemW-1:0] r21;
    logic [ElemW-1:0] r22;
    logic             singular;
    logic             saturated;
  } out_word_t;

  // Cofactors in row-major order of the adjugate, plus column 0 of the matrix.
  typedef struct packed {
    logic [8:0][CofW-1:0]  cof;
    logic [2:0][ElemW-1:0] col;
  } cof_word_t;

  typedef struct packed {
    logic [DetW-1:0]      det;
    logic [8:0][CofW-1:0] cof;
  } det_word_t;

  typedef struct packed {
    logic [MagW-1:0]  rem;
    logic [ElemW-1:0] quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic            singular;
    logic [MagW-1:0] dmag;
    lane_t [8:0]     lane;
  } dv_word_t;

endpackage

@@ src/mi3_cofactor.sv @@
// Two-stage cofactor unit: eighteen 32x32 products, then nine differences.
`timescale 1ns / 1ps
module mi3_cofactor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mi3_pkg::in_word_t   word_i,
  output logic                valid_o,
  output mi3_pkg::cof_word_t  word_o
);
  import mi3_pkg::*;

  function automatic logic [CofW-1:0] smul(logic [ElemW-1:0] x, logic [ElemW-1:0] y);
    logic signed [CofW-1:0] xe;
    logic signed [CofW-1:0] ye;
    xe = $signed({{(CofW-ElemW){x[ElemW-1]}}, x});
    ye = $signed({{(CofW-ElemW){y[ElemW-1]}}, y});
    return CofW'(xe * ye);
  endfunction

  logic [ElemW-1:0] m [9];
  logic [8:0][CofW-1:0] pa_d, pb_d, pa_q, pb_q;
  logic [2:0][ElemW-1:0] col_q;
  logic valid_a_q;
  cof_word_t word_d, word_q;
  logic valid_q;

  always_comb begin
    m[0] = word_i.a00; m[1] = word_i.a01; m[2] = word_i.a02;
    m[3] = word_i.a10; m[4] = word_i.a11; m[5] = word_i.a12;
    m[6] = word_i.a20; m[7] = word_i.a21; m[8] = word_i.a22;
    pa_d[0] = smul(m[4], m[8]); pb_d[0] = smul(m[5], m[7]);
    pa_d[1] = smul(m[7], m[2]); pb_d[1] = smul(m[1], m[8]);
    pa_d[2] = smul(m[1], m[5]); pb_d[2] = smul(m[4], m[2]);
    pa_d[3] = smul(m[6], m[5]); pb_d[3] = smul(m[3], m[8]);
    pa_d[4] = smul(m[0], m[8]); pb_d[4] = smul(m[6], m[2]);
    pa_d[5] = smul(m[3], m[2]); pb_d[5] = smul(m[0], m[5]);
    pa_d[6] = smul(m[3], m[7]); pb_d[6] = smul(m[6], m[4]);
    pa_d[7] = smul(m[6], m[1]); pb_d[7] = smul(m[0], m[7]);
    pa_d[8] = smul(m[0], m[4]); pb_d[8] = smul(m[3], m[1]);
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      word_d.cof[k] = pa_q[k] - pb_q[k];
    end
    word_d.col = col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_q   <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      col_q  <= {m[6], m[3], m[0]};
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ src/mi3_det.sv @@
// Three-stage determinant unit: partial products, term assembly, final sum.
`timescale 1ns / 1ps
module mi3_det (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mi3_pkg::cof_word_t  word_i,
  output logic                valid_o,
  output mi3_pkg::det_word_t  word_o
);
  import mi3_pkg::*;

  // Each 32x64 product is split: element times the signed upper half of the
  // cofactor, and element times the unsigned lower half.
  logic [2:0][CofW-1:0] ph_d, ph_q;
  logic [2:0][CofW:0]   pl_d, pl_q;
  logic [2:0][DetW-1:0] term_d, term_q;
  logic [DetW-1:0]      det_d;
  logic [8:0][CofW-1:0] cof_c_q, cof_d_q;
  det_word_t            word_q;
  logic [2:0]           valid_q;

  always_comb begin
    logic signed [CofW-1:0] me;
    logic signed [CofW-1:0] he;
    logic signed [CofW:0]   ml;
    logic signed [CofW:0]   le;
    for (int j = 0; j < 3; j++) begin
      me = $signed({{(CofW-ElemW){word_i.col[j][ElemW-1]}}, word_i.col[j]});
      he = $signed({{(CofW-32){word_i.cof[j][CofW-1]}}, word_i.cof[j][CofW-1:32]});
      ml = $signed({{(CofW+1-ElemW){word_i.col[j][ElemW-1]}}, word_i.col[j]});
      le = $signed({{(CofW+1-32){1'b0}}, word_i.cof[j][31:0]});
      ph_d[j] = CofW'(me * he);
      pl_d[j] = (CofW+1)'(ml * le);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      term_d[j] = {{(DetW-CofW-32){ph_q[j][CofW-1]}}, ph_q[j], 32'd0}
                + {{(DetW-CofW-1){pl_q[j][CofW]}}, pl_q[j]};
    end
    det_d = term_q[0] + term_q[1] + term_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q       <= ph_d;
      pl_q       <= pl_d;
      cof_c_q    <= word_i.cof;
      term_q     <= term_d;
      cof_d_q    <= cof_c_q;
      word_q.det <= det_d;
      word_q.cof <= cof_d_q;
    end
  end

  assign valid_o = valid_q[2];
  assign word_o  = word_q;

endmodule

@@ src/mi3_div_step.sv @@
// One restoring-division stage: one quotient bit for each of the nine lanes.
`timescale 1ns / 1ps
module mi3_div_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  mi3_pkg::dv_word_t  word_i,
  output logic               valid_o,
  output mi3_pkg::dv_word_t  word_o
);
  import mi3_pkg::*;

  dv_word_t word_d, word_q;
  logic     valid_q;

  // Where the remainder starts below the divisor it stays below it, so after
  // subtraction it fits back into the magnitude width.
  always_comb begin
    logic [MagW:0] rem2;
    word_d = word_i;
    for (int k = 0; k < 9; k++) begin
      rem2 = {word_i.lane[k].rem, 1'b0};
      if (rem2 >= {1'b0, word_i.dmag}) begin
        word_d.lane[k].rem = MagW'(rem2 - {1'b0, word_i.dmag});
        word_d.lane[k].quo = {word_i.lane[k].quo[ElemW-2:0], 1'b1};
      end else begin
        word_d.lane[k].rem = rem2[MagW-1:0];
        word_d.lane[k].quo = {word_i.lane[k].quo[ElemW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ src/matrix3x3_inverse.sv @@
// Top level of the pipelined 3x3 Q16.16 matrix inverse by the adjugate.
//
//   channel   direction  handshake                word
//   in        input      in_valid_i / in_stall_o  in_word_i  (a00 .. a22)
//   out       output     out_valid_o / out_stall_i out_word_o (r00 .. r22, flags)
//
// A matrix enters every cycle the input is not stalled; each result passes
// through 2 cofactor, 3 determinant, 1 preparation, 32 division, 1 output stage.
// The latency is set by the 32 restoring-division stages, one quotient bit each.
// Reset clears only the valid bits; there is nothing else to clear.
// Stalling a waiting result freezes all stages, so nothing is lost or repeated.
`timescale 1ns / 1ps
module matrix3x3_inverse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mi3_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mi3_pkg::out_word_t out_word_o
);
  import mi3_pkg::*;

  logic       en;
  logic       cof_valid, det_valid, prep_valid_q, out_valid_q;
  cof_word_t  cof_word;
  det_word_t  det_word;
  dv_word_t   prep_d, prep_q;
  out_word_t  out_d, out_q;
  logic       dv_valid [Steps+1];
  dv_word_t   dv_word  [Steps+1];

  assign en         = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~en;

  mi3_cofactor u_cof (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .word_i(in_word_i),
    .valid_o(cof_valid), .word_o(cof_word)
  );

  mi3_det u_det (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(cof_valid), .word_i(cof_word),
    .valid_o(det_valid), .word_o(det_word)
  );

  // Magnitudes and signs. A quotient of 2^32 or more shows up at once as
  // cofactor magnitude not below the determinant magnitude.
  always_comb begin
    logic [CofW-1:0] cm;
    prep_d.singular = (det_word.det == '0);
    prep_d.dmag = det_word.det[DetW-1] ? MagW'(-det_word.det) : det_word.det[MagW-1:0];
    for (int k = 0; k < 9; k++) begin
      cm = det_word.cof[k][CofW-1] ? -det_word.cof[k] : det_word.cof[k];
      prep_d.lane[k].rem = {{(MagW-CofW){1'b0}}, cm};
      prep_d.lane[k].quo = '0;
      prep_d.lane[k].neg = det_word.cof[k][CofW-1] ^ det_word.det[DetW-1];
      prep_d.lane[k].ovf = ({{(MagW-CofW){1'b0}}, cm} >= prep_d.dmag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  assign dv_valid[0] = prep_valid_q;
  assign dv_word[0]  = prep_q;

  for (genvar s = 0; s < Steps; s++) begin : g_div
    mi3_div_step u_step (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv_valid[s]), .word_i(dv_word[s]),
      .valid_o(dv_valid[s+1]), .word_o(dv_word[s+1])
    );
  end

  // Sign, saturation and the singular override.
  always_comb begin
    logic [ElemW-1:0] r [9];
    logic             sat;
    lane_t            ln;
    sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      ln = dv_word[Steps].lane[k];
      if (ln.neg) begin
        if (ln.ovf || (ln.quo > {1'b1, {(ElemW-1){1'b0}}})) begin
          r[k] = {1'b1, {(ElemW-1){1'b0}}};
          sat  = 1'b1;
        end else begin
          r[k] = -ln.quo;
        end
      end else begin
        if (ln.ovf || ln.quo[ElemW-1]) begin
          r[k] = {1'b0, {(ElemW-1){1'b1}}};
          sat  = 1'b1;
        end else begin
          r[k] = ln.quo;
        end
      end
      if (dv_word[Steps].singular) begin
        r[k] = '0;
      end
    end
    out_d.r00 = r[0]; out_d.r01 = r[1]; out_d.r02 = r[2];
    out_d.r10 = r[3]; out_d.r11 = r[4]; out_d.r12 = r[5];
    out_d.r20 = r[6]; out_d.r21 = r[7]; out_d.r22 = r[8];
    out_d.singular  = dv_word[Steps].singular;
    out_d.saturated = sat & ~dv_word[Steps].singular;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (en) begin
      prep_valid_q <= det_valid;
      out_valid_q  <= dv_valid[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.singular |->
      !out_word_o.saturated && out_word_o.r00 == '0 && out_word_o.r11 == '0 &&
      out_word_o.r22 == '0 && out_word_o.r01 == '0 && out_word_o.r20 == '0)
    else $error("singular word carries non-zero data");

  a_frozen_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dv_valid[Steps]))
    else $error("pipeline moved while the output was stalled");

endmodule
